[src/sws_pkg.sv]
// ----------------------------------------------------------------------------
// sws_pkg : shared types and constants for the sliding window std deviation
// Fixed output format, opcodes, register reset and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package sws_pkg;

  // result format: 24-bit deviation with 8 fraction bits
  localparam int DEV_BITS  = 24;
  localparam int FRAC_BITS = 8;
  // variance carries twice the fraction bits of the root
  localparam int VAR_FRAC  = 2 * FRAC_BITS;
  localparam int QUO_BITS  = 2 * DEV_BITS;
  // quotient of the integer variance saturates at or above 2^SAT_SHIFT
  localparam int SAT_SHIFT = QUO_BITS - VAR_FRAC;

  localparam logic [DEV_BITS-1:0] DEV_MAX = '1;

  localparam int HELD_BITS = 5;
  localparam int CFG_BITS  = 5;
  localparam logic [CFG_BITS-1:0] CFG_WIN_RESET = 5'd8;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_WAIT,
    ST_UPDATE,
    ST_MUL,
    ST_MUL_WAIT,
    ST_CHECK,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SQRT_WAIT,
    ST_OUT
  } sws_state_t;

endpackage

`default_nettype wire

[src/sliding_window_std_dev.sv]
// ----------------------------------------------------------------------------
// sliding_window_std_dev : running standard deviation over a sample window
// Ring of recent samples with running sum and sum of squares, serial
// multipliers, divider and square root.
// ----------------------------------------------------------------------------
// Each input transaction either adds an unsigned sample (evicting the oldest
// one once the window holds window_size samples) or clears the history, and
// yields one result transaction: floor(256 * unbiased std deviation), a flag
// that at least two samples are held, and the held count. The block works on
// one transaction at a time. An add runs the sample squaring pass, the
// n*sumsq and sum^2 shift-add pass, the divider and the square root, all
// one bit a cycle. A clear, or an add that leaves fewer than two samples or
// zero variance, skips the divider and root. in_stall is high while a
// transaction is in work; a finished result sits in the output register
// while the next input is accepted. The user must write window_size through
// the cfg port only while idle; the block does not enforce it;
// change it only after a clear.
// The ring holds no reset state.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_std_dev #(
  parameter int MAX_WINDOW  = 16,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration: window_size
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sws_pkg::CFG_BITS-1:0]     cfg_data,
  // input transactions
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_operation,
  input  wire logic [SAMPLE_BITS-1:0]           in_sample,
  // result transactions
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [sws_pkg::DEV_BITS-1:0]          out_deviation,
  output logic                                  out_dev_valid,
  output logic [sws_pkg::HELD_BITS-1:0]         out_held_count
);

  import sws_pkg::*;

  // widths derived from the window and sample size
  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int CW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int SQW  = 2 * SAMPLE_BITS + CW;
  localparam int DW   = 2 * SUMW;
  localparam int MDW  = 2 * CW;
  localparam logic [AW+1:0] MAXW_S = (AW + 2)'(MAX_WINDOW);

  function automatic logic [AW-1:0] wrap_slot(input logic [AW+1:0] s);
    return (s >= MAXW_S) ? AW'(s - MAXW_S) : AW'(s);
  endfunction

  sws_state_t state_r, state_nxt;

  // architectural state
  logic [CFG_BITS-1:0]    cfg_win_r;
  logic [AW-1:0]          ptr_r;
  logic [CW-1:0]          cnt_r;
  logic [SUMW-1:0]        sum_r;
  logic [SQW-1:0]         sumsq_r;
  logic [SAMPLE_BITS-1:0] ring_mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_r;

  // per-transaction working registers
  logic [SAMPLE_BITS-1:0] sample_r;
  logic                   evict_r;
  logic                   gt_r;
  logic [DW-1:0]          diff_r;
  logic [MDW-1:0]         m_r;
  logic [DEV_BITS-1:0]    res_dev_r;
  logic                   res_vld_r;

  // output register
  logic                   out_valid_r;
  logic [DEV_BITS-1:0]    out_dev_r;
  logic                   out_dvld_r;
  logic [HELD_BITS-1:0]   out_held_r;

  logic                   in_fire;
  logic                   out_fire;
  logic [CW-1:0]          win_eff;

  // controller strobes
  logic sq_start, mul_start, div_start, sqrt_start, out_load;
  logic res_zero, res_zero_vld, res_sat, res_root;

  // serial units
  logic                     sqn_busy, sqo_busy, mn_busy, mss_busy, div_busy, sqrt_busy;
  logic [2*SAMPLE_BITS-1:0] sq_new, sq_old;
  logic [DW-1:0]            prod_nsq, prod_ss;
  logic                     div_sat;
  logic [QUO_BITS-1:0]      div_quo;
  logic [DEV_BITS-1:0]      sqrt_root;

  // update-step values
  logic [AW-1:0]          ptr_base;
  logic [CW-1:0]          cnt_base;
  logic [AW-1:0]          wr_slot;
  logic [SAMPLE_BITS-1:0] old_s;
  logic [2*SAMPLE_BITS-1:0] old_sq;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid_r && !out_stall;

  // window size zero acts as one, oversize saturates at the ring depth
  always_comb begin
    if (cfg_win_r == '0) begin
      win_eff = CW'(1);
    end else if (32'(cfg_win_r) > MAX_WINDOW) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(cfg_win_r);
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    sq_start     = 1'b0;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    sqrt_start   = 1'b0;
    out_load     = 1'b0;
    res_zero     = 1'b0;
    res_zero_vld = 1'b0;
    res_sat      = 1'b0;
    res_root     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_CLEAR) begin
            res_zero  = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            sq_start  = 1'b1;
            state_nxt = ST_SQ_WAIT;
          end
        end
      end
      ST_SQ_WAIT: begin
        if (!sqn_busy && !sqo_busy) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (!mn_busy && !mss_busy) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r < CW'(2)) begin
          res_zero  = 1'b1;
          state_nxt = ST_OUT;
        end else if (!gt_r) begin
          res_zero_vld = 1'b1;
          state_nxt    = ST_OUT;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (!div_busy) begin
          if (div_sat) begin
            res_sat   = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            sqrt_start = 1'b1;
            state_nxt  = ST_SQRT_WAIT;
          end
        end
      end
      ST_SQRT_WAIT: begin
        if (!sqrt_busy) begin
          res_root  = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // wait for the output register to drain
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- window
  // after an eviction the oldest slot moves on and the count drops by one,
  // then the new sample lands right after the youngest held one
  assign ptr_base = evict_r ? wrap_slot((AW + 2)'(ptr_r) + (AW + 2)'(1)) : ptr_r;
  assign cnt_base = evict_r ? cnt_r - CW'(1) : cnt_r;
  assign wr_slot  = wrap_slot((AW + 2)'(ptr_base) + (AW + 2)'(cnt_base));
  assign old_s    = evict_r ? rd_r : '0;
  assign old_sq   = evict_r ? sq_old : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_win_r   <= CFG_WIN_RESET;
      ptr_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      sumsq_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_win_r <= cfg_data;
      end
      if (in_fire && in_operation == OP_CLEAR) begin
        ptr_r   <= '0;
        cnt_r   <= '0;
        sum_r   <= '0;
        sumsq_r <= '0;
      end
      if (state_r == ST_UPDATE) begin
        ptr_r   <= ptr_base;
        cnt_r   <= cnt_base + CW'(1);
        sum_r   <= sum_r - SUMW'(old_s) + SUMW'(sample_r);
        sumsq_r <= sumsq_r - SQW'(old_sq) + SQW'(sq_new);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // sample ring: one write port, registered read of the oldest slot
  always_ff @(posedge clk) begin
    if (state_r == ST_UPDATE) begin
      ring_mem[wr_slot] <= sample_r;
    end
    rd_r <= ring_mem[ptr_r];
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sample_r <= in_sample;
      evict_r  <= (cnt_r >= win_eff);
    end
    if (state_r == ST_CHECK) begin
      gt_r   <= prod_nsq > prod_ss;
      diff_r <= prod_nsq - prod_ss;
      m_r    <= MDW'(MDW'(cnt_r) * MDW'(cnt_r - CW'(1)));
    end
    if (res_zero || res_zero_vld) begin
      res_dev_r <= '0;
      res_vld_r <= res_zero_vld;
    end
    if (res_sat) begin
      res_dev_r <= DEV_MAX;
      res_vld_r <= 1'b1;
    end
    if (res_root) begin
      res_dev_r <= sqrt_root;
      res_vld_r <= 1'b1;
    end
    if (out_load) begin
      out_dev_r  <= res_dev_r;
      out_dvld_r <= res_vld_r;
      out_held_r <= HELD_BITS'(cnt_r);
    end
  end

  // squares of the incoming and the evicted sample
  sws_mul #(.WA(SAMPLE_BITS), .WB(SAMPLE_BITS)) u_sq_new (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .a     (in_sample),
    .b     (in_sample),
    .busy  (sqn_busy),
    .prod  (sq_new)
  );

  sws_mul #(.WA(SAMPLE_BITS), .WB(SAMPLE_BITS)) u_sq_old (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .a     (rd_r),
    .b     (rd_r),
    .busy  (sqo_busy),
    .prod  (sq_old)
  );

  // n * sumsq and sum^2
  sws_mul #(.WA(SQW), .WB(CW)) u_mul_nsq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (sumsq_r),
    .b     (cnt_r),
    .busy  (mn_busy),
    .prod  (prod_nsq)
  );

  sws_mul #(.WA(SUMW), .WB(SUMW)) u_mul_ss (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (sum_r),
    .b     (sum_r),
    .busy  (mss_busy),
    .prod  (prod_ss)
  );

  // variance * 2^16 = floor((n*sumsq - sum^2) * 2^16 / (n*(n-1)))
  sws_div #(.DW(DW), .MDW(MDW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .d     (diff_r),
    .m     (m_r),
    .busy  (div_busy),
    .sat   (div_sat),
    .quo   (div_quo)
  );

  sws_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .x     (div_quo),
    .busy  (sqrt_busy),
    .root  (sqrt_root)
  );

  assign out_valid      = out_valid_r;
  assign out_deviation  = out_dev_r;
  assign out_dev_valid  = out_dvld_r;
  assign out_held_count = out_held_r;

endmodule

`default_nettype wire

[src/sws_mul.sv]
// ----------------------------------------------------------------------------
// sws_mul : bit-serial shift-add multiplier
// One multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_mul #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [WA-1:0]    a,
  input  wire logic [WB-1:0]    b,
  output logic                  busy,
  output logic [WA+WB-1:0]      prod
);

  localparam int WP   = WA + WB;
  localparam int CNTW = $clog2(WB + 1);

  logic [WP-1:0]   mcand_r;
  logic [WP-1:0]   acc_r;
  logic [WB-1:0]   mplier_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(WB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= WP'(a);
      mplier_r <= b;
      acc_r    <= '0;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

[src/sws_div.sv]
// ----------------------------------------------------------------------------
// sws_div : restoring divider for the scaled variance
// Gives floor(d * 2^VAR_FRAC / m), one quotient bit per cycle, plus a flag
// when the integer quotient reaches 2^SAT_SHIFT.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_div #(
  parameter int DW  = 40,
  parameter int MDW = 10
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [DW-1:0]                d,
  input  wire logic [MDW-1:0]               m,
  output logic                              busy,
  output logic                              sat,
  output logic [sws_pkg::QUO_BITS-1:0]      quo
);

  import sws_pkg::*;

  localparam int CMPW = (DW > MDW + SAT_SHIFT) ? DW : MDW + SAT_SHIFT;
  localparam int CNTW = $clog2(QUO_BITS + 1);

  logic [CMPW-1:0]     dext;
  logic [CMPW-1:0]     dhi;
  logic [MDW:0]        trial;
  logic                fits;
  logic [MDW-1:0]      m_r;
  logic [MDW-1:0]      rem_r;
  logic [QUO_BITS-1:0] lo_r;
  logic [QUO_BITS-1:0] quo_r;
  logic                sat_r;
  logic [CNTW-1:0]     cnt_r;
  logic                busy_r;

  assign dext  = CMPW'(d);
  assign dhi   = dext >> SAT_SHIFT;
  assign trial = {rem_r, lo_r[QUO_BITS-1]};
  assign fits  = trial >= {1'b0, m_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(QUO_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // when not saturated d >> SAT_SHIFT is below m, so it seeds the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= m;
      sat_r <= dext >= (CMPW'(m) << SAT_SHIFT);
      rem_r <= MDW'(dhi);
      lo_r  <= {dext[SAT_SHIFT-1:0], VAR_FRAC'(0)};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? MDW'(trial - {1'b0, m_r}) : MDW'(trial);
      lo_r  <= lo_r << 1;
      quo_r <= {quo_r[QUO_BITS-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign sat  = sat_r;
  assign quo  = quo_r;

endmodule

`default_nettype wire

[src/sws_sqrt.sv]
// ----------------------------------------------------------------------------
// sws_sqrt : bit-serial integer square root
// Two radicand bits in, one root bit out per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sws_sqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [sws_pkg::QUO_BITS-1:0]  x,
  output logic                               busy,
  output logic [sws_pkg::DEV_BITS-1:0]       root
);

  import sws_pkg::*;

  localparam int CNTW = $clog2(DEV_BITS + 1);
  localparam int RW   = DEV_BITS + 2;

  logic [QUO_BITS-1:0] x_r;
  logic [RW-1:0]       rem_r;
  logic [DEV_BITS-1:0] root_r;
  logic [RW+1:0]       rem_sh;
  logic [RW+1:0]       trial;
  logic                fits;
  logic [CNTW-1:0]     cnt_r;
  logic                busy_r;

  assign rem_sh = {rem_r, x_r[QUO_BITS-1 -: 2]};
  assign trial  = (RW + 2)'({root_r, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNTW'(DEV_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= x_r << 2;
      rem_r  <= fits ? RW'(rem_sh - trial) : RW'(rem_sh);
      root_r <= {root_r[DEV_BITS-2:0], fits};
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

`default_nettype wire
